// ----- src/lzss_pkg.sv -----
// ============================================================================
// lzss_pkg
// Shared types and constants of the LZSS stream decompressor.
// ============================================================================
package lzss_pkg;

   localparam int HEADER_BYTES = 12;
   localparam int MAGIC_BYTES  = 4;
   localparam int MIN_RUN      = 3;

   typedef enum logic [2:0] {
      ST_RUNNING  = 3'd0,
      ST_DONE     = 3'd1,
      ST_BAD_MAGIC = 3'd2,
      ST_LEN_MISM = 3'd3,
      ST_BAD_OFF  = 3'd4,
      ST_OVERRUN  = 3'd5,
      ST_TRUNC    = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_TOKENS = 2'd1,
      PH_DONE   = 2'd2,
      PH_ERROR  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      FSM_IDLE  = 3'd0,
      FSM_BITS  = 3'd1,
      FSM_COPY  = 3'd2,
      FSM_WAIT  = 3'd3,
      FSM_FLUSH = 3'd4,
      FSM_OUT   = 3'd5
   } fsm_type;

   localparam logic CSR_MAGIC  = 1'b0;
   localparam logic CSR_LENGTH = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture input item
      logic bit_step;  // process one token bit
      logic copy_rd;   // issue history read for a match byte
      logic copy_wr;   // write returned byte
      logic flush;     // move lane buffer to output
      logic finish;    // end of item bookkeeping
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_tokens;
      logic bits_left;
      logic match_go;
      logic copy_left;
      logic copy_more;  // more than one match byte still to copy
      logic lane_last;  // next byte fills the lane buffer
      logic out_busy;
   } stat_type;

endpackage

// ----- src/lzss_bitstream_decompressor.sv -----
// ============================================================================
// lzss_bitstream_decompressor
// LZSS stream decompressor: header check, token parse, 64 KiB history.
// ============================================================================
//  channel | dir | handshake        | payload
//  req     | in  | req_valid/stall  | in_byte, in_last
//  rsp     | out | rsp_valid/stall  | out_data, out_count, status, out_end
//  csr     | in  | csr_valid/ready  | csr_index, csr_data
//
//  A byte is loaded, then parsed token bit by token bit; a match reads each byte
//  from the history RAM (registered read), writes it back, and sends a full beat
//  whenever the lane buffer fills before the match ends.
//  Synchronous active-high reset; the history has no clearing pass.
//  rsp_stall holds the sequencer; req is stalled while an item is in work.
module lzss_bitstream_decompressor
   import lzss_pkg::*;
#(
   parameter int HISTORY_DEPTH = 65536,
   parameter int OUT_LANES     = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_out_data,
   output logic [3:0]  rsp_out_count,
   output logic [2:0]  rsp_status,
   output logic        rsp_out_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   lzss_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   lzss_dp #(.HISTORY_DEPTH(HISTORY_DEPTH), .OUT_LANES(OUT_LANES)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_data (rsp_out_data),
      .rsp_out_count(rsp_out_count),
      .rsp_status   (rsp_status),
      .rsp_out_end  (rsp_out_end)
   );

endmodule

// ----- src/lzss_ram.sv -----
// ============================================================================
// lzss_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module lzss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/lzss_ctrl.sv -----
// ============================================================================
// lzss_ctrl
// Sequencer: bit steps of a byte, match copy loop, beat flushes.
// ============================================================================
module lzss_ctrl
   import lzss_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               state_in = FSM_BITS;
            end
         end
         FSM_BITS: begin
            if (stat.match_go) begin
               state_in = FSM_COPY;
            end else if (!stat.is_tokens || !stat.bits_left) begin
               state_in = FSM_OUT;
            end
         end
         FSM_COPY: begin
            state_in = FSM_WAIT;
         end
         FSM_WAIT: begin
            if (!stat.copy_more) begin
               state_in = FSM_BITS;
            end else if (stat.lane_last) begin
               state_in = FSM_FLUSH;
            end else begin
               state_in = FSM_COPY;
            end
         end
         FSM_FLUSH: begin
            if (!stat.out_busy) begin
               if (stat.copy_left) begin
                  state_in = FSM_COPY;
               end else begin
                  state_in = FSM_BITS;
               end
            end
         end
         FSM_OUT: begin
            if (!stat.out_busy) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         FSM_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         FSM_BITS: begin
            cmd.bit_step = stat.is_tokens && stat.bits_left && !stat.match_go;
         end
         FSM_COPY:  cmd.copy_rd = 1'b1;
         FSM_WAIT:  cmd.copy_wr = 1'b1;
         FSM_FLUSH: cmd.flush   = !stat.out_busy;
         FSM_OUT:   cmd.finish  = !stat.out_busy;
         default: ;
      endcase
   end

endmodule

// ----- src/lzss_dp.sv -----
// ============================================================================
// lzss_dp
// Datapath: header and token parsing, history, lane packing, output register.
// ============================================================================
module lzss_dp
   import lzss_pkg::*;
#(
   parameter int HISTORY_DEPTH = 65536,
   parameter int OUT_LANES     = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_out_data,
   output logic [3:0]  rsp_out_count,
   output logic [2:0]  rsp_status,
   output logic        rsp_out_end
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int LW = $clog2(OUT_LANES + 1);
   localparam int IW = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;

   logic [31:0] magic_ff, explen_ff;
   phase_type   phase_ff, phase_in;
   status_type  err_ff, err_in;
   logic [3:0]  hidx_ff, hidx_in;
   logic [63:0] hsh_ff, hsh_in;
   logic [24:0] tsh_ff, tsh_in;
   logic [4:0]  tcnt_ff, tcnt_in;
   logic [31:0] bw_ff, bw_in;
   logic [7:0]  byte_ff;
   logic        last_ff;
   logic [3:0]  bit_ff, bit_in;
   logic [8:0]  run_ff, run_in;
   logic [15:0] off_ff, off_in;
   logic        mgo_ff, mgo_in;
   logic [7:0]  lane_ff [OUT_LANES];
   logic [7:0]  lane_in [OUT_LANES];
   logic [LW-1:0] lcnt_ff, lcnt_in;
   logic        ovalid_ff, ovalid_in;
   logic [63:0] odata_ff, odata_in;
   logic [3:0]  ocnt_ff, ocnt_in;
   logic [2:0]  ostat_ff, ostat_in;
   logic        oend_ff, oend_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;

   lzss_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   logic        out_busy;
   logic        cur_bit;
   logic [24:0] tsh_nx;
   logic [4:0]  tcnt_nx;
   logic        flag;
   logic [7:0]  put_val;
   logic        put_en;
   logic [2:0]  cur_status;
   logic [63:0] pack;

   assign out_busy = ovalid_ff && rsp_stall;
   assign cur_bit  = byte_ff[bit_ff[2:0]];
   assign tsh_nx   = {tsh_ff[23:0], cur_bit};
   assign tcnt_nx  = tcnt_ff + 5'd1;
   assign flag     = tsh_nx[tcnt_ff];
   assign rd_addr  = AW'(bw_ff - 32'(off_ff));
   assign wr_addr  = AW'(bw_ff);
   assign wr_data  = put_val;
   assign wr_en    = put_en;

   assign stat.is_tokens  = (phase_ff == PH_TOKENS);
   assign stat.bits_left  = !bit_ff[3];
   assign stat.match_go   = mgo_ff;
   assign stat.copy_left  = (run_ff != 9'd0);
   assign stat.copy_more  = (run_ff > 9'd1);
   assign stat.lane_last  = (lcnt_ff == LW'(OUT_LANES - 1));
   assign stat.out_busy   = out_busy;

   // a beat flushed mid-match carries the status the item ends with
   always_comb begin
      case (phase_ff)
         PH_DONE:  cur_status = ST_DONE;
         PH_ERROR: cur_status = err_ff;
         default:  cur_status = ST_RUNNING;
      endcase
      if (phase_ff == PH_TOKENS && run_ff != 9'd0
          && bw_ff + 32'(run_ff) == explen_ff) begin
         cur_status = ST_DONE;
      end else if (last_ff && (phase_ff == PH_HEADER || phase_ff == PH_TOKENS)) begin
         cur_status = ST_TRUNC;
      end
      pack = '0;
      for (int j = 0; j < OUT_LANES; j++) begin
         if (LW'(j) < lcnt_ff) begin
            pack[8*j +: 8] = lane_ff[j];
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      err_in   = err_ff;
      hidx_in  = hidx_ff;
      hsh_in   = hsh_ff;
      tsh_in   = tsh_ff;
      tcnt_in  = tcnt_ff;
      bw_in    = bw_ff;
      bit_in   = bit_ff;
      run_in   = run_ff;
      off_in   = off_ff;
      mgo_in   = 1'b0;
      lane_in  = lane_ff;
      lcnt_in  = lcnt_ff;
      ovalid_in = ovalid_ff && rsp_stall;
      odata_in = odata_ff;
      ocnt_in  = ocnt_ff;
      ostat_in = ostat_ff;
      oend_in  = oend_ff;
      put_en   = 1'b0;
      put_val  = rd_data;

      if (cmd.load) begin
         bit_in = 4'd7;
         if (phase_ff == PH_HEADER) begin
            if (hidx_ff < 4'(MAGIC_BYTES)) begin
               hsh_in = hsh_ff | (64'(req_in_byte) << {hidx_ff[1:0], 3'b000});
               hidx_in = hidx_ff + 4'd1;
               if (hidx_ff == 4'(MAGIC_BYTES - 1)) begin
                  hsh_in = '0;
                  if (hsh_ff[23:0] != magic_ff[23:0]
                      || req_in_byte != magic_ff[31:24]) begin
                     phase_in = PH_ERROR;
                     err_in   = ST_BAD_MAGIC;
                  end
               end
            end else begin
               hsh_in = hsh_ff | (64'(req_in_byte) << {hidx_ff[2:0] - 3'd4, 3'b000});
               hidx_in = hidx_ff + 4'd1;
               if (hidx_ff == 4'(HEADER_BYTES - 1)) begin
                  if (hsh_in != 64'(explen_ff)) begin
                     phase_in = PH_ERROR;
                     err_in   = ST_LEN_MISM;
                  end else if (explen_ff == 32'd0) begin
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_TOKENS;
                  end
               end
            end
         end
      end

      if (cmd.bit_step) begin
         bit_in  = bit_ff - 4'd1;
         tsh_in  = tsh_nx;
         tcnt_in = tcnt_nx;
         if (!flag && tcnt_nx == 5'd9) begin
            tsh_in  = '0;
            tcnt_in = '0;
            put_en  = 1'b1;
            put_val = tsh_nx[7:0];
            lane_in[lcnt_ff[IW-1:0]] = tsh_nx[7:0];
            lcnt_in = lcnt_ff + LW'(1);
            bw_in   = bw_ff + 32'd1;
            if (bw_in == explen_ff) begin
               phase_in = PH_DONE;
            end
         end else if (flag && tcnt_nx == 5'd25) begin
            tsh_in  = '0;
            tcnt_in = '0;
            if (tsh_nx[15:0] == 16'd0 || 32'(tsh_nx[15:0]) > bw_ff) begin
               phase_in = PH_ERROR;
               err_in   = ST_BAD_OFF;
            end else if (33'(bw_ff) + 33'(tsh_nx[23:16]) + 33'(MIN_RUN)
                         > 33'(explen_ff)) begin
               phase_in = PH_ERROR;
               err_in   = ST_OVERRUN;
            end else begin
               run_in = 9'(tsh_nx[23:16]) + 9'(MIN_RUN);
               off_in = tsh_nx[15:0];
               mgo_in = 1'b1;
            end
         end
      end

      if (cmd.copy_wr) begin
         put_en  = 1'b1;
         lane_in[lcnt_ff[IW-1:0]] = rd_data;
         lcnt_in = lcnt_ff + LW'(1);
         bw_in   = bw_ff + 32'd1;
         run_in  = run_ff - 9'd1;
         if (run_ff == 9'd1 && bw_in == explen_ff) begin
            phase_in = PH_DONE;
         end
      end

      if (cmd.flush || cmd.finish) begin
         ovalid_in = 1'b1;
         odata_in  = pack;
         ocnt_in   = 4'(lcnt_ff);
         ostat_in  = cur_status;
         oend_in   = cmd.finish;
         lcnt_in   = '0;
         if (cmd.finish && last_ff) begin
            phase_in = PH_HEADER;
            err_in   = ST_RUNNING;
            hidx_in  = '0;
            hsh_in   = '0;
            tsh_in   = '0;
            tcnt_in  = '0;
            bw_in    = '0;
         end else if (cmd.finish && cur_status == ST_TRUNC) begin
            phase_in = PH_ERROR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff  <= '0;
         explen_ff <= '0;
         phase_ff  <= PH_HEADER;
         err_ff    <= ST_RUNNING;
         hidx_ff   <= '0;
         hsh_ff    <= '0;
         tsh_ff    <= '0;
         tcnt_ff   <= '0;
         bw_ff     <= '0;
         bit_ff    <= 4'd8;
         run_ff    <= '0;
         mgo_ff    <= 1'b0;
         lcnt_ff   <= '0;
         ovalid_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MAGIC) begin
               magic_ff <= csr_data;
            end else begin
               explen_ff <= csr_data;
            end
         end
         phase_ff  <= phase_in;
         err_ff    <= err_in;
         hidx_ff   <= hidx_in;
         hsh_ff    <= hsh_in;
         tsh_ff    <= tsh_in;
         tcnt_ff   <= tcnt_in;
         bw_ff     <= bw_in;
         bit_ff    <= (cmd.load && phase_ff != PH_TOKENS) ? 4'd8 : bit_in;
         run_ff    <= run_in;
         mgo_ff    <= mgo_in;
         lcnt_ff   <= lcnt_in;
         ovalid_ff <= ovalid_in;
         if (cmd.load) begin
            last_ff <= req_in_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         byte_ff <= req_in_byte;
      end
      off_ff   <= off_in;
      lane_ff  <= lane_in;
      odata_ff <= odata_in;
      ocnt_ff  <= ocnt_in;
      ostat_ff <= ostat_in;
      oend_ff  <= oend_in;
   end

   assign rsp_valid     = ovalid_ff;
   assign rsp_out_data  = odata_ff;
   assign rsp_out_count = ocnt_ff;
   assign rsp_status    = ostat_ff;
   assign rsp_out_end   = oend_ff;

endmodule

// ----- src/lzss_checker.sv -----
// ============================================================================
// lzss_checker
// Port-level checks of the decompressor.
// ============================================================================
module lzss_checker
   import lzss_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_out_data,
   input logic [3:0]  rsp_out_count,
   input logic [2:0]  rsp_status
);

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_count <= 4'd8)
      else $error("count above eight");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= 3'(ST_TRUNC))
      else $error("bad status code");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_data))
      else $error("stalled item changed");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while busy");

endmodule

bind lzss_bitstream_decompressor lzss_checker u_chk (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_data (rsp_out_data),
   .rsp_out_count(rsp_out_count),
   .rsp_status   (rsp_status)
);

// ----- bench/tb_top.sv -----
// ============================================================================
// tb_top
// Self-checking bench for the LZSS stream decompressor.
// Builds compressed streams of literal and match tokens, clean and broken,
// runs them through the block under random gaps and stalls, and checks every
// output beat against a behavioural model of the header, token and history
// logic.
// ============================================================================
`timescale 1ns / 100ps

module tb_top;
   import lzss_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  count;
      status_type  status;
      logic        last;
   } beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = '0;
   logic        req_in_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_out_data;
   logic [3:0]  rsp_out_count;
   logic [2:0]  rsp_status;
   logic        rsp_out_end;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_MAGIC;
   logic [31:0] csr_data = '0;

   lzss_bitstream_decompressor DUT (.*);

   always #4 clock = ~clock;

   // decoder model state
   logic [31:0] cfg_magic, cfg_length;
   phase_type   ph;
   int unsigned hdr_idx;
   logic [63:0] hdr_shift;
   logic [24:0] tok_shift;
   int unsigned tok_count;
   logic [31:0] produced;
   status_type  fault;
   logic [7:0]  history [65536];
   logic [7:0]  made [$];
   beat_type    pending_beats [$];

   // stream builder
   bit          tok_bits [$];
   logic [7:0]  stream [$];
   int          built_len;

   int          mismatches = 0;
   int          burst_left = 0;
   int          hold_asked = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   int          idle_cycles = 0;

   function automatic void rearm();
      ph = PH_HEADER;
      hdr_idx = 0;
      hdr_shift = '0;
      tok_shift = '0;
      tok_count = 0;
      produced = '0;
      fault = ST_RUNNING;
   endfunction

   function automatic void emit_byte(logic [7:0] v);
      history[produced[15:0]] = v;
      made.push_back(v);
      produced++;
   endfunction

   function automatic void decode_bit(bit b);
      logic [31:0] run;
      logic [15:0] off;
      tok_shift = {tok_shift[23:0], b};
      tok_count++;
      if (!tok_shift[tok_count-1] && tok_count == 9) begin
         emit_byte(tok_shift[7:0]);
         tok_shift = '0;
         tok_count = 0;
      end else if (tok_shift[tok_count-1] && tok_count == 25) begin
         run = tok_shift[23:16] + MIN_RUN;
         off = tok_shift[15:0];
         tok_shift = '0;
         tok_count = 0;
         if (off == 0 || off > produced) begin
            ph = PH_ERROR;
            fault = ST_BAD_OFF;
            return;
         end
         if ({32'd0, produced} + run > {32'd0, cfg_length}) begin
            ph = PH_ERROR;
            fault = ST_OVERRUN;
            return;
         end
         for (int i = 0; i < run; i++)
            emit_byte(history[16'(produced - off)]);
      end else
         return;
      if (ph == PH_TOKENS && produced == cfg_length)
         ph = PH_DONE;
   endfunction

   function automatic void predict_beats(logic [7:0] b, logic last);
      beat_type   bt;
      status_type st;
      int         beats;
      made.delete();
      if (ph == PH_HEADER) begin
         if (hdr_idx < MAGIC_BYTES) begin
            hdr_shift |= 64'(b) << (8 * hdr_idx);
            hdr_idx++;
            if (hdr_idx == MAGIC_BYTES) begin
               if (hdr_shift[31:0] != cfg_magic) begin
                  ph = PH_ERROR;
                  fault = ST_BAD_MAGIC;
               end
               hdr_shift = '0;
            end
         end else begin
            hdr_shift |= 64'(b) << (8 * ((hdr_idx - MAGIC_BYTES) & 7));
            hdr_idx++;
            if (hdr_idx >= HEADER_BYTES) begin
               if (hdr_shift != {32'd0, cfg_length}) begin
                  ph = PH_ERROR;
                  fault = ST_LEN_MISM;
               end else if (cfg_length == 0)
                  ph = PH_DONE;
               else
                  ph = PH_TOKENS;
            end
         end
      end else if (ph == PH_TOKENS) begin
         for (int k = 7; k >= 0 && ph == PH_TOKENS; k--)
            decode_bit(b[k]);
      end
      if (last && (ph == PH_HEADER || ph == PH_TOKENS)) begin
         ph = PH_ERROR;
         fault = ST_TRUNC;
      end
      st = (ph == PH_DONE) ? ST_DONE : (ph == PH_ERROR) ? fault : ST_RUNNING;
      beats = (made.size() == 0) ? 1 : (made.size() + 7) / 8;
      for (int k = 0; k < beats; k++) begin
         bt = '0;
         for (int j = 0; j < 8; j++)
            if (k * 8 + j < made.size()) begin
               bt.data[8*j +: 8] = made[k*8+j];
               bt.count++;
            end
         bt.status = st;
         bt.last = (k + 1 == beats);
         pending_beats.push_back(bt);
      end
      if (last)
         rearm();
   endfunction

   // --- driving ---------------------------------------------------------
   task automatic send_byte(logic [7:0] b, logic last);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 10);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      @(negedge clock);
      while (req_stall)
         @(negedge clock);
      @(posedge clock);
      predict_beats(b, last);
      burst_left--;
   endtask

   task automatic wait_idle();
      @(posedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_beats.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      while (!csr_ready)
         @(negedge clock);
      @(posedge clock);
      if (idx == CSR_MAGIC)
         cfg_magic = value;
      else
         cfg_length = value;
   endtask

   task automatic set_regs(logic [31:0] magic, logic [31:0] len);
      wait_idle();
      write_reg(CSR_MAGIC, magic);
      write_reg(CSR_LENGTH, len);
      csr_valid <= 1'b0;
   endtask

   function automatic void add_literal(logic [7:0] v);
      tok_bits.push_back(1'b0);
      for (int k = 7; k >= 0; k--)
         tok_bits.push_back(v[k]);
      built_len++;
   endfunction

   function automatic void add_copy(logic [7:0] code, logic [15:0] off);
      logic [23:0] f;
      f = {code, off};
      tok_bits.push_back(1'b1);
      for (int k = 23; k >= 0; k--)
         tok_bits.push_back(f[k]);
      built_len += code + MIN_RUN;
   endfunction

   // header plus packed token bits; the tail of the last byte is zero
   function automatic void pack_stream(logic [31:0] magic, logic [63:0] len);
      logic [7:0] v;
      stream.delete();
      for (int k = 0; k < 4; k++)
         stream.push_back(magic[8*k +: 8]);
      for (int k = 0; k < 8; k++)
         stream.push_back(len[8*k +: 8]);
      while (tok_bits.size() % 8 != 0)
         tok_bits.push_back(1'b0);
      for (int k = 0; k < tok_bits.size(); k += 8) begin
         for (int j = 0; j < 8; j++)
            v[7-j] = tok_bits[k+j];
         stream.push_back(v);
      end
      tok_bits.delete();
      built_len = 0;
   endfunction

   task automatic send_stream(int drop);
      int n;
      n = stream.size() - drop;
      for (int k = 0; k < n; k++)
         send_byte(stream[k], k == n - 1);
   endtask

   // --- response side ---------------------------------------------------
   always @(posedge clock) begin
      int mode;
      mode = int'(($time / 512) % 4);
      if (reset)
         rsp_stall <= 1'b0;
      else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_seen) begin
         hold_seen <= hold_asked;
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ((($time / 8) % 5) < 2);
         endcase
   end

   always @(posedge clock) begin
      beat_type exp_beat;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected beat data=%h count=%0d status=%0d end=%0d",
                        rsp_out_data, rsp_out_count, rsp_status, rsp_out_end);
         end else begin
            exp_beat = pending_beats.pop_front();
            if (rsp_out_data !== exp_beat.data || rsp_out_count !== exp_beat.count ||
                rsp_status !== exp_beat.status || rsp_out_end !== exp_beat.last) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("beat mismatch exp %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                           exp_beat.data, exp_beat.count, exp_beat.status,
                           exp_beat.last, rsp_out_data, rsp_out_count,
                           rsp_status, rsp_out_end);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // --- tests -----------------------------------------------------------
   task automatic test_literals_and_copies();
      set_regs(32'h5A17C3E9, 32'd13);
      add_literal(8'h00);
      add_literal(8'hFF);
      add_literal(8'h80);
      add_literal(8'h01);
      add_copy(8'd0, 16'd1);
      add_copy(8'd2, 16'd4);
      add_literal(8'h7E);
      for (int k = 0; k < 3; k++)
         tok_bits.push_back(1'b1);
      pack_stream(32'h5A17C3E9, 64'd13);
      send_stream(0);
   endtask

   task automatic test_longest_copy();
      set_regs(32'hFFFFFFFF, 32'd259);
      add_literal(8'hA5);
      add_copy(8'd255, 16'd1);
      pack_stream(32'hFFFFFFFF, 64'd259);
      send_stream(0);
   endtask

   task automatic test_header_faults();
      set_regs(32'h00000000, 32'd0);
      pack_stream(32'h00000001, 64'd0);
      send_stream(0);
      pack_stream(32'h00000000, 64'h0000_0001_0000_0000);
      send_stream(0);
      // zero length: done at once, trailing bytes ignored
      add_literal(8'h55);
      pack_stream(32'h00000000, 64'd0);
      send_stream(0);
   endtask

   task automatic test_token_faults();
      set_regs(32'hC0DE0001, 32'd10);
      add_literal(8'h11);
      add_copy(8'd0, 16'd0);
      pack_stream(32'hC0DE0001, 64'd10);
      send_stream(0);
      add_literal(8'h22);
      add_copy(8'd0, 16'd2);
      pack_stream(32'hC0DE0001, 64'd10);
      send_stream(0);
      add_literal(8'h33);
      add_copy(8'd7, 16'd1);
      pack_stream(32'hC0DE0001, 64'd10);
      send_stream(0);
   endtask

   task automatic test_truncation();
      set_regs(32'h12345678, 32'hFFFFFFFF);
      pack_stream(32'h12345678, 64'hFFFFFFFF);
      send_stream(5);
      add_literal(8'h9C);
      add_copy(8'd4, 16'd1);
      pack_stream(32'h12345678, 64'hFFFFFFFF);
      send_stream(0);
   endtask

   task automatic random_stream(int fault_kind);
      int          n;
      int          drop;
      logic [31:0] magic;
      logic [7:0]  code;
      n = $urandom_range(1, 30);
      magic = $urandom;
      set_regs(magic, n);
      drop = 0;
      while (built_len < n) begin
         if (built_len == 0 || n - built_len < 3 || $urandom_range(0, 2) == 0)
            add_literal($urandom);
         else begin
            code = $urandom_range(0, (n - built_len - 3 > 255) ? 255 : n - built_len - 3);
            if ($urandom_range(0, 1) == 0 && code > 12)
               code = $urandom_range(0, 12);
            add_copy(code, $urandom_range(1, built_len));
         end
      end
      case (fault_kind)
         0: begin
            tok_bits.delete();
            built_len = 0;
            add_literal($urandom);
            add_copy($urandom_range(0, 3), ($urandom_range(0, 1) == 0) ? 16'd0 : 16'd2);
         end
         1: begin
            tok_bits.delete();
            built_len = 0;
            add_literal($urandom);
            add_copy(8'd255, 16'd1);
         end
         2: drop = $urandom_range(1, 3);
         3: magic = ~magic;
         default:
            for (int k = $urandom_range(0, 15); k > 0; k--)
               tok_bits.push_back($urandom_range(0, 1));
      endcase
      pack_stream(magic, n);
      if (drop >= stream.size())
         drop = 0;
      send_stream(drop);
   endtask

   task automatic test_random_streams();
      int sent;
      sent = 0;
      while (sent < 12) begin
         if ($urandom_range(0, 9) == 0) begin
            for (int k = $urandom_range(1, 15); k > 0; k--) begin
               send_byte($urandom, k == 1);
               sent++;
            end
         end else begin
            random_stream($urandom_range(0, 9));
            sent += stream.size();
         end
      end
   endtask

   task automatic test_backpressure();
      set_regs(32'hBEEF0042, 32'd8);
      for (int k = 0; k < 8; k++)
         add_literal($urandom);
      pack_stream(32'hBEEF0042, 64'd8);
      wait_idle();
      hold_asked++;
      burst_left = 1000;
      send_stream(0);
   endtask

   initial begin
      cfg_magic = '0;
      cfg_length = '0;
      built_len = 0;
      rearm();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_literals_and_copies();
      test_longest_copy();
      test_header_faults();
      test_token_faults();
      test_truncation();
      test_backpressure();
      test_random_streams();
      wait_idle();
      repeat (600) @(posedge clock);
      if (mismatches == 0 && pending_beats.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
